// ===== hw/rtl/losm_pkg.sv =====
// Shared types and constants for the log-odds score matrix unit.
package losm_pkg;
	localparam int MaxSymbols = 32;
	localparam int LogFracBits = 16;
	localparam int NumRegs = 5;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_TABLE_SIZE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CONTAINS_X = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BIT_FACTOR = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SCORING_BIAS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ANY_BACK = 3'd4;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_SAT = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic op;
		logic [4:0] row_index;
		logic [4:0] col_index;
		logic [31:0] probability;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic [31:0] cond_ratio;
		logic [1:0] status;
	} out_beat_t;
endpackage

// ===== hw/rtl/losm_stream_if.sv =====
// Valid/ready stream interface used for input and result beats.
interface losm_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/losm_divider.sv =====
// Restoring divider retiring one quotient bit per cycle.
module losm_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] num,
	input logic [32:0] den,
	output logic done,
	output logic [31:0] quot,
	output logic sat
);
	// Dividend is num << 28 (60 bits); quotient up to 60 bits, saturate above 32.
	logic [59:0] dvd_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [31:0] quot_q;
	logic sat_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [33:0] trial;
	logic [33:0] diff;
	logic ge;

	assign trial = {rem_q[32:0], dvd_q[59]};
	assign diff = trial - {1'b0, den_q};
	assign ge = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd59;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// Datapath: shift one dividend bit into the remainder each cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 28'd0};
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[58:0], 1'b0};
			rem_q <= ge ? diff : trial;
			quot_q <= {quot_q[30:0], ge};
			if (quot_q[31]) sat_q <= 1'b1;
		end
	end

	assign quot = sat_q ? 32'hFFFF_FFFF : quot_q;
	assign sat = sat_q;
endmodule

// ===== hw/rtl/losm_log2.sv =====
// Log2 unit: normalization one bit per cycle, then one squaring per fraction bit.
module losm_log2 #(
	parameter int LogFracBits = losm_pkg::LogFracBits
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [32:0] x,
	output logic done,
	output logic [LogFracBits+5:0] result
);
	localparam int RW = LogFracBits + 6;
	localparam int CW = $clog2(LogFracBits + 1);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR = 3'b100
	} lstate_t;

	lstate_t state_q;
	logic [32:0] m_q;
	logic [5:0] e_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] k_q;
	logic [65:0] sq;
	logic [33:0] msh;

	// Mantissa held as 1.31 in 33 bits during squaring.
	assign sq = {33'd0, m_q} * {33'd0, m_q};
	assign msh = sq[64:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done <= 1'b0;
			k_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				L_IDLE: if (start) state_q <= L_NORM;
				L_NORM: begin
					if (m_q[32:31] == 2'b01) begin
						state_q <= L_SQR;
						k_q <= '0;
					end
				end
				L_SQR: begin
					k_q <= k_q + CW'(1);
					if (k_q == CW'(LogFracBits - 1)) begin
						state_q <= L_IDLE;
						done <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// Normalize by single shifts, tracking the exponent.
	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			m_q <= x;
			e_q <= 6'd31;
		end else if (state_q == L_NORM) begin
			if (m_q[32]) begin
				m_q <= {1'b0, m_q[32:1]};
				e_q <= e_q + 6'd1;
			end else if (!m_q[31]) begin
				m_q <= {m_q[31:0], 1'b0};
				e_q <= e_q - 6'd1;
			end else begin
				r_q <= RW'(e_q);
			end
		end else if (state_q == L_SQR) begin
			if (msh[32]) begin
				m_q <= msh[33:1];
				r_q <= {r_q[RW-2:0], 1'b1};
			end else begin
				m_q <= msh[32:0];
				r_q <= {r_q[RW-2:0], 1'b0};
			end
		end
	end

	assign result = r_q;
endmodule

// ===== hw/rtl/log_odds_score_matrix_unit.sv =====
// Log-odds score matrix unit: one item in work at a time; a write passes through a memory read state
// and a write state. A read runs three log2 values in turn through one log2 unit beside the ratio
// divider. An index out of range or a zero column background goes straight to the output; another
// zero operand skips the logs but still waits for the divider.
// A finished result waits in an output register and holds off input until taken. Reset restores
// the register defaults, clears row sums via valid bits, then zeroes all 1024 table entries.
module log_odds_score_matrix_unit #(
	parameter int LogFracBits = losm_pkg::LogFracBits
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [losm_pkg::CfgIdxW-1:0] cfg_index,
	input logic [losm_pkg::CfgDataW-1:0] cfg_data,
	losm_stream_if.sink in_if,
	losm_stream_if.source out_if
);
	localparam int MaxSymbols = losm_pkg::MaxSymbols;
	localparam int SW = $clog2(MaxSymbols);
	localparam int RW = LogFracBits + 6;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_WRD = 9'b000000010,
		S_RDM = 9'b000000100,
		S_LP = 9'b000001000,
		S_LI = 9'b000010000,
		S_LJ = 9'b000100000,
		S_MUL = 9'b001000000,
		S_FIN = 9'b010000000,
		S_OUT = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0] table_size_q;
	logic contains_x_q;
	logic [15:0] bit_factor_q;
	logic signed [15:0] scoring_bias_q;
	logic [31:0] any_back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= 6'd21;
			contains_x_q <= 1'b1;
			bit_factor_q <= 16'd512;
			scoring_bias_q <= '0;
			any_back_q <= 32'd42950;
		end else if (cfg_we) begin
			unique case (cfg_index)
				losm_pkg::REG_TABLE_SIZE: table_size_q <= cfg_data[5:0];
				losm_pkg::REG_CONTAINS_X: contains_x_q <= cfg_data[0];
				losm_pkg::REG_BIT_FACTOR: bit_factor_q <= cfg_data[15:0];
				losm_pkg::REG_SCORING_BIAS: scoring_bias_q <= cfg_data[15:0];
				losm_pkg::REG_ANY_BACK: any_back_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective table size.
	logic [6:0] n_eff;
	always_comb begin
		if (table_size_q == 6'd0) n_eff = 7'd1;
		else if ({1'b0, table_size_q} > 7'(MaxSymbols)) n_eff = 7'(MaxSymbols);
		else n_eff = {1'b0, table_size_q};
	end

	// Captured input item.
	losm_pkg::in_beat_t item_q;
	logic in_range;
	assign in_range = ({2'b0, item_q.row_index} < 7'(MaxSymbols))
		&& ({2'b0, item_q.col_index} < 7'(MaxSymbols));

	// Probability memory and row sums with valid bits.
	logic [31:0] prob_mem [MaxSymbols*MaxSymbols];
	logic [32:0] row_sum_q [MaxSymbols];
	logic [MaxSymbols-1:0] rs_valid_q;
	logic [31:0] pdata_q;
	logic [2*SW-1:0] maddr;
	assign maddr = {item_q.row_index[SW-1:0], item_q.col_index[SW-1:0]};

	// After reset the whole table is zeroed, one entry per cycle.
	logic [2*SW-1:0] clr_addr_q;
	logic clr_busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + (2*SW)'(1);
			if (&clr_addr_q) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) prob_mem[clr_addr_q] <= '0;
		else if (state_q == S_WRD && in_range) prob_mem[maddr] <= item_q.probability;
		pdata_q <= prob_mem[maddr];
	end

	// Row background, taken while the memory read is under way.
	logic [SW-1:0] bsel;
	logic [32:0] bsel_val;
	logic [32:0] bi_q, bj_q;
	always_comb begin
		bsel = item_q.row_index[SW-1:0];
		if (contains_x_q && {2'b0, bsel} == 7'(n_eff - 7'd1)) bsel_val = {1'b0, any_back_q};
		else if (rs_valid_q[bsel]) bsel_val = row_sum_q[bsel];
		else bsel_val = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rs_valid_q <= '0;
		else if (state_q == S_WRD && in_range)
			rs_valid_q[item_q.row_index[SW-1:0]] <= 1'b1;
	end

	logic [32:0] cur_sum;
	assign cur_sum = rs_valid_q[item_q.row_index[SW-1:0]] ?
		row_sum_q[item_q.row_index[SW-1:0]] : 33'd0;
	always_ff @(posedge clk) begin
		if (state_q == S_WRD && in_range)
			row_sum_q[item_q.row_index[SW-1:0]] <=
				cur_sum - {1'b0, pdata_q} + {1'b0, item_q.probability};
	end

	// Log2 unit shared by the three logs, and the ratio divider.
	logic lg_start, lg_done;
	logic [32:0] lg_x;
	logic [RW-1:0] lg_res;
	losm_log2 #(.LogFracBits(LogFracBits)) u_log2 (
		.clk(clk), .arst_n(arst_n), .start(lg_start), .x(lg_x),
		.done(lg_done), .result(lg_res)
	);

	logic dv_start, dv_done, dv_sat, dv_done_q;
	logic [31:0] dv_quot;
	losm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(pdata_q), .den(bj_q),
		.done(dv_done), .quot(dv_quot), .sat(dv_sat)
	);

	logic [RW-1:0] lp_q, li_q;
	logic signed [RW+1:0] l_q;
	logic signed [RW+19:0] s_q;
	logic zero_q, idx_bad_q;
	logic zero_now;
	logic started_q;
	losm_pkg::out_beat_t res_q;

	// Score rounding from the registered product.
	localparam int SW2 = RW + 20;
	logic [SW2-1:0] mag;
	logic [SW2-1:0] qv;
	logic signed [SW2-1:0] bias_term;
	assign mag = s_q[SW2-1] ? SW2'(-s_q) : SW2'(s_q);
	assign qv = (mag + (SW2'(1) << (LogFracBits + 7))) >> (LogFracBits + 8);
	assign bias_term = SW2'(scoring_bias_q) <<< LogFracBits;

	// A zero operand skips logs; divider runs on in-range indices with nonzero column background.
	assign zero_now = (pdata_q == 32'd0) || (bi_q == 33'd0) || (bj_q == 33'd0);
	assign lg_start = !started_q && (((state_q == S_LP) && !idx_bad_q && !zero_now)
		|| (state_q == S_LI) || (state_q == S_LJ));
	always_comb begin
		unique case (state_q)
			S_LP: lg_x = {1'b0, pdata_q};
			S_LI: lg_x = bi_q;
			default: lg_x = bj_q;
		endcase
	end
	assign dv_start = (state_q == S_LP) && !started_q && !idx_bad_q && (bj_q != 33'd0);

	assign in_if.ready = (state_q == S_IDLE) && !out_if.valid && !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
			dv_done_q <= 1'b0;
			out_if.valid <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) out_if.valid <= 1'b0;
			if (dv_done) dv_done_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (in_if.valid && in_if.ready) state_q <= S_RDM;
				end
				S_WRD: state_q <= S_IDLE;
				S_RDM: begin
					started_q <= 1'b0;
					dv_done_q <= 1'b0;
					state_q <= (item_q.op == losm_pkg::OP_WRITE) ? S_WRD : S_LP;
				end
				S_LP: begin
					started_q <= 1'b1;
					if (idx_bad_q) state_q <= S_OUT;
					else if (zero_now) begin
						if (bj_q == 33'd0 || dv_done_q || dv_done) state_q <= S_OUT;
					end else if (lg_done) begin
						started_q <= 1'b0;
						state_q <= S_LI;
					end
				end
				S_LI: begin
					started_q <= 1'b1;
					if (lg_done) begin
						started_q <= 1'b0;
						state_q <= S_LJ;
					end
				end
				S_LJ: begin
					started_q <= 1'b1;
					if (lg_done) begin
						started_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: if (dv_done_q) state_q <= S_OUT;
				S_OUT: begin
					out_if.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Read datapath.
	always_ff @(posedge clk) begin
		if (in_if.valid && in_if.ready) item_q <= in_if.data;
		if (state_q == S_RDM) begin
			bi_q <= bsel_val;
			idx_bad_q <= ({2'b0, item_q.row_index} >= n_eff)
				|| ({2'b0, item_q.col_index} >= n_eff);
		end
		if (state_q == S_LP) zero_q <= zero_now;
		if (state_q == S_LP && lg_done) lp_q <= lg_res;
		if (state_q == S_LI && lg_done) li_q <= lg_res;
		if (state_q == S_LJ && lg_done)
			l_q <= $signed({2'b0, lp_q}) - $signed({2'b0, li_q}) - $signed({2'b0, lg_res})
				+ $signed((RW+2)'(32) <<< LogFracBits);
		if (state_q == S_MUL)
			s_q <= $signed({1'b0, bit_factor_q}) * $signed(SW2'(l_q)) + bias_term;
		if (state_q == S_OUT) begin
			if (idx_bad_q) begin
				res_q.score <= '0;
				res_q.cond_ratio <= '0;
				res_q.status <= losm_pkg::STATUS_ZERO;
			end else begin
				res_q.cond_ratio <= (bj_q == 33'd0) ? 32'd0 : dv_quot;
				if (zero_q) begin
					res_q.score <= '0;
					res_q.status <= losm_pkg::STATUS_ZERO;
				end else begin
					res_q.status <= dv_sat ? losm_pkg::STATUS_SAT : losm_pkg::STATUS_OK;
					if (s_q[SW2-1]) begin
						if (qv > SW2'(32768)) begin
							res_q.score <= 16'sh8000;
							res_q.status <= losm_pkg::STATUS_SAT;
						end else res_q.score <= 16'(-qv);
					end else begin
						if (qv > SW2'(32767)) begin
							res_q.score <= 16'sh7FFF;
							res_q.status <= losm_pkg::STATUS_SAT;
						end else res_q.score <= qv[15:0];
					end
				end
			end
		end
	end

	// The column background is taken alongside the row background.
	logic [SW-1:0] col_sel;
	logic [32:0] col_val;
	assign col_sel = item_q.col_index[SW-1:0];
	always_comb begin
		if (contains_x_q && {2'b0, col_sel} == 7'(n_eff - 7'd1)) col_val = {1'b0, any_back_q};
		else if (rs_valid_q[col_sel]) col_val = row_sum_q[col_sel];
		else col_val = '0;
	end
	always_ff @(posedge clk) begin
		if (state_q == S_RDM) bj_q <= col_val;
	end

	assign out_if.data = res_q;
endmodule
